@@ sv/dtl_pkg.sv @@
// ----------------------------------------------------------------------------
// dtl_pkg
// Shared types and codes of the door encoder travel limiter: register
// indexes, input codes, the command word passed from front to back end.
// ----------------------------------------------------------------------------
package dtl_pkg;

  // configuration port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DIR_POL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PCT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SPAN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESTORED_END = 3'd4;

  // input word codes
  localparam logic [1:0] MODE_PULSE       = 2'd0;
  localparam logic [1:0] MODE_TICK        = 2'd1;
  localparam logic [1:0] MODE_MARK_CLOSED = 2'd2;
  localparam logic [1:0] MODE_MARK_OPEN   = 2'd3;

  localparam logic [1:0] MOTION_OPENING = 2'd1;
  localparam logic [1:0] MOTION_CLOSING = 2'd2;

  // remembered end codes
  localparam logic [1:0] LIMIT_NONE   = 2'd0;
  localparam logic [1:0] LIMIT_CLOSED = 2'd1;
  localparam logic [1:0] LIMIT_OPEN   = 2'd2;

  // direction codes
  localparam logic signed [1:0] DIR_NONE  = 2'sb00;
  localparam logic signed [1:0] DIR_OPEN  = 2'sb01;
  localparam logic signed [1:0] DIR_CLOSE = 2'sb11;

  // register reset values
  localparam logic                RST_DIR_POL   = 1'b1;
  localparam logic [6:0]          RST_SLOW_PCT  = 7'd10;
  localparam logic [15:0]         RST_DEBOUNCE  = 16'd500;
  localparam logic signed [23:0]  RST_INIT_SPAN = 24'sd10000;
  localparam logic [1:0]          RST_RESTORED  = LIMIT_NONE;

  // slowdown zone scale (percent)
  localparam int SLOW_SCALE = 100;

  // command queue depth
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_PULSE_OPEN,
    OP_PULSE_CLOSE,
    OP_TICK_OPEN,
    OP_TICK_CLOSE,
    OP_TICK_IDLE,
    OP_MARK_CLOSED,
    OP_MARK_OPEN
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now_ms;
  } cmd_t;

  typedef enum logic [1:0] {
    SLOW_HOLD,
    SLOW_CLEAR,
    SLOW_EVAL
  } slow_op_t;

  typedef struct packed {
    logic        dir_high_close;
    logic [6:0]  slow_pct;
    logic [15:0] debounce;
  } cfg_t;

  typedef struct packed {
    logic       load_span;
    logic       load_end;
    logic       pct_write;
    logic [1:0] end_val;
  } cfg_evt_t;

endpackage

@@ sv/dtl_front.sv @@
// ----------------------------------------------------------------------------
// dtl_front
// Input side: takes words from the input channel and turns mode, motion and
// direction level into one command for the back end queue.
// ----------------------------------------------------------------------------
module dtl_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    mode,
  input  logic          dir_level,
  input  logic [31:0]   now_ms,
  input  logic [1:0]    motion,
  input  logic          dir_high_close,
  input  logic          q_full,
  output logic          push,
  output dtl_pkg::cmd_t cmd
);
  import dtl_pkg::*;

  logic pulse_close;

  // take a word whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // pin level read under the polarity setting
  assign pulse_close = !(dir_high_close ^ dir_level);

  // classify the word
  always_comb begin
    cmd.now_ms = now_ms;
    case (mode)
      MODE_PULSE: begin
        cmd.op = pulse_close ? OP_PULSE_CLOSE : OP_PULSE_OPEN;
      end
      MODE_TICK: begin
        if (motion == MOTION_OPENING) begin
          cmd.op = OP_TICK_OPEN;
        end else if (motion == MOTION_CLOSING) begin
          cmd.op = OP_TICK_CLOSE;
        end else begin
          cmd.op = OP_TICK_IDLE;
        end
      end
      MODE_MARK_CLOSED: cmd.op = OP_MARK_CLOSED;
      MODE_MARK_OPEN:   cmd.op = OP_MARK_OPEN;
      default:          cmd.op = OP_TICK_IDLE;
    endcase
  end

endmodule

@@ sv/dtl_queue.sv @@
// ----------------------------------------------------------------------------
// dtl_queue
// Short command queue between front and back end so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module dtl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dtl_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  output dtl_pkg::cmd_t head,
  input  logic          pop
);
  import dtl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign valid = (count != '0);
  assign head  = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ sv/dtl_back.sv @@
// ----------------------------------------------------------------------------
// dtl_back
// Execution side: holds position, span, end mark and stop timer, runs one
// command per cycle unless stalled; slow flag settles in output register.
// ----------------------------------------------------------------------------
module dtl_back #(
  parameter int POS_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dtl_pkg::cfg_t                       cfg,
  input  dtl_pkg::cfg_evt_t                   evt,
  input  logic signed [dtl_pkg::CFG_DATA_W-1:0] span_raw,
  input  logic                                q_valid,
  input  dtl_pkg::cmd_t                       q_cmd,
  output logic                                q_pop,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [POS_WIDTH-1:0]         position,
  output logic signed [1:0]                   direction,
  output logic                                slow,
  output logic                                stop_request,
  output logic [1:0]                          door_end,
  output logic signed [POS_WIDTH-1:0]         open_span,
  output logic                                persist
);
  import dtl_pkg::*;

  localparam int DIST_W = POS_WIDTH + 1;
  localparam int PROD_W = POS_WIDTH + 7;
  localparam int CMP_W  = POS_WIDTH + 9;
  localparam int RAW_W  = 33;

  localparam longint POS_MAX_L  = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
  localparam longint POS_MIN_L  = -(longint'(1) <<< (POS_WIDTH - 1));
  localparam longint SPAN_RST_L = (longint'(RST_INIT_SPAN) > POS_MAX_L) ?
                                  POS_MAX_L : longint'(RST_INIT_SPAN);

  localparam logic signed [POS_WIDTH-1:0] POS_MAX  = POS_WIDTH'(POS_MAX_L);
  localparam logic signed [POS_WIDTH-1:0] POS_MIN  = POS_WIDTH'(POS_MIN_L);
  localparam logic signed [POS_WIDTH-1:0] SPAN_RST = POS_WIDTH'(SPAN_RST_L);
  localparam logic signed [RAW_W-1:0]     RAW_MAX  = RAW_W'(POS_MAX_L);
  localparam logic signed [RAW_W-1:0]     RAW_MIN  = RAW_W'(POS_MIN_L);

  // tracked state
  logic signed [POS_WIDTH-1:0] pos;
  logic signed [1:0]           dir_sign;
  logic signed [POS_WIDTH-1:0] span;
  logic [31:0]                 last_stop;
  logic [1:0]                  end_mark;
  logic                        slow_flag;

  // slowdown product of span and percent, refreshed every cycle
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    prod_mul;
  logic                        prod_ok;

  // execute stage result waiting for the output register
  logic                        a_valid;
  logic                        a_stop;
  logic                        a_persist;
  slow_op_t                    a_slow_op;
  logic signed [DIST_W-1:0]    a_dmin;
  logic signed [PROD_W-1:0]    a_prod;

  // next values of one command
  logic signed [POS_WIDTH-1:0] pos_next;
  logic signed [1:0]           dir_next;
  logic signed [POS_WIDTH-1:0] span_next;
  logic [31:0]                 last_stop_next;
  logic [1:0]                  end_next;
  logic                        stop_next;
  logic                        persist_next;
  slow_op_t                    slow_op_next;

  logic                        at_open;
  logic                        at_closed;
  logic                        at_end;
  logic                        stop_ok;
  logic [31:0]                 elapsed;
  logic signed [DIST_W-1:0]    pos_x;
  logic signed [DIST_W-1:0]    to_open;
  logic signed [DIST_W-1:0]    dmin;
  logic signed [RAW_W-1:0]     span_raw_x;
  logic signed [POS_WIDTH-1:0] span_cfg;
  logic                        span_change;
  logic                        adv_out;
  logic signed [CMP_W-1:0]     dist_scaled;
  logic signed [CMP_W-1:0]     thr_bound;
  logic                        slow_eval;

  // handshake between queue, execute stage and output register
  assign adv_out = a_valid && (!out_valid || out_ready);
  assign q_pop   = q_valid && prod_ok && (!a_valid || adv_out);

  // span written at startup, saturated to the position range
  assign span_raw_x = RAW_W'(span_raw);
  always_comb begin
    if (span_raw_x > RAW_MAX) begin
      span_cfg = POS_MAX;
    end else if (span_raw_x < RAW_MIN) begin
      span_cfg = POS_MIN;
    end else begin
      span_cfg = span_raw_x[POS_WIDTH-1:0];
    end
  end

  // end and debounce tests
  assign at_open   = (pos >= span);
  assign at_closed = (pos <= POS_WIDTH'(0));
  assign elapsed   = q_cmd.now_ms - last_stop;
  assign stop_ok   = (elapsed >= {16'd0, cfg.debounce});

  // distance to the nearer end
  assign pos_x   = DIST_W'(pos);
  assign to_open = DIST_W'(span) - pos_x;
  assign dmin    = (pos_x < to_open) ? pos_x : to_open;

  // command execution
  always_comb begin
    pos_next       = pos;
    dir_next       = dir_sign;
    span_next      = span;
    last_stop_next = last_stop;
    end_next       = end_mark;
    stop_next      = 1'b0;
    persist_next   = 1'b0;
    slow_op_next   = SLOW_HOLD;
    at_end         = (q_cmd.op == OP_TICK_OPEN) ? at_open : at_closed;
    case (q_cmd.op)
      OP_PULSE_OPEN: begin
        dir_next = DIR_OPEN;
        if (pos != POS_MAX) begin
          pos_next = pos + POS_WIDTH'(1);
        end
      end
      OP_PULSE_CLOSE: begin
        dir_next = DIR_CLOSE;
        if (pos != POS_MIN) begin
          pos_next = pos - POS_WIDTH'(1);
        end
      end
      OP_TICK_OPEN, OP_TICK_CLOSE: begin
        slow_op_next = SLOW_EVAL;
        if (at_end) begin
          if (stop_ok) begin
            stop_next      = 1'b1;
            last_stop_next = q_cmd.now_ms;
            if (at_closed) begin
              pos_next     = '0;
              end_next     = LIMIT_CLOSED;
              persist_next = 1'b1;
            end else if (at_open) begin
              pos_next     = span;
              end_next     = LIMIT_OPEN;
              persist_next = 1'b1;
            end
          end
          // closing at the closed end always pins the door shut
          if (q_cmd.op == OP_TICK_CLOSE) begin
            pos_next     = '0;
            end_next     = LIMIT_CLOSED;
            persist_next = 1'b1;
          end
        end
      end
      OP_TICK_IDLE: begin
        slow_op_next = SLOW_CLEAR;
      end
      OP_MARK_CLOSED: begin
        pos_next     = '0;
        end_next     = LIMIT_CLOSED;
        persist_next = 1'b1;
      end
      OP_MARK_OPEN: begin
        span_next    = pos;
        end_next     = LIMIT_OPEN;
        persist_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // span times percent, operands widened to the product width
  assign prod_mul = PROD_W'(span) * $signed({{POS_WIDTH{1'b0}}, cfg.slow_pct});

  assign span_change = (q_pop && (q_cmd.op == OP_MARK_OPEN)) || evt.load_span;

  // slow test: dist <= trunc(prod / 100) as a compare without division
  assign dist_scaled = CMP_W'(a_dmin) * CMP_W'(SLOW_SCALE);
  assign thr_bound   = CMP_W'(a_prod) +
                       ((a_prod < 0) ? CMP_W'(SLOW_SCALE - 1) : CMP_W'(0));
  assign slow_eval   = (dist_scaled <= thr_bound);

  // state, execute stage and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      dir_sign  <= DIR_NONE;
      span      <= SPAN_RST;
      last_stop <= '0;
      end_mark  <= RST_RESTORED;
      slow_flag <= 1'b0;
      prod_ok   <= 1'b0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        pos       <= pos_next;
        dir_sign  <= dir_next;
        span      <= span_next;
        last_stop <= last_stop_next;
        end_mark  <= end_next;
      end else begin
        if (evt.load_span) begin
          span <= span_cfg;
        end
        if (evt.load_end) begin
          end_mark <= evt.end_val;
          if (evt.end_val == LIMIT_CLOSED) begin
            pos <= '0;
          end else if (evt.end_val == LIMIT_OPEN) begin
            pos <= span;
          end
        end
      end
      prod_ok <= !(span_change || evt.pct_write);
      if (q_pop) begin
        a_valid <= 1'b1;
      end else if (adv_out) begin
        a_valid <= 1'b0;
      end
      if (adv_out) begin
        out_valid <= 1'b1;
        case (a_slow_op)
          SLOW_CLEAR: slow_flag <= 1'b0;
          SLOW_EVAL:  slow_flag <= slow_eval;
          default:    slow_flag <= slow_flag;
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod <= prod_mul;
    if (q_pop) begin
      a_stop    <= stop_next;
      a_persist <= persist_next;
      a_slow_op <= slow_op_next;
      a_dmin    <= dmin;
      a_prod    <= prod;
    end
    if (adv_out) begin
      position     <= pos;
      direction    <= dir_sign;
      door_end     <= end_mark;
      open_span    <= span;
      stop_request <= a_stop;
      persist      <= a_persist;
    end
  end

  assign slow = slow_flag;

endmodule

@@ sv/door_encoder_travel_limiter.sv @@
// ----------------------------------------------------------------------------
// door_encoder_travel_limiter
// Door travel tracking from encoder pulses, ticks and end marks, with slow
// zone, debounced stop request and end recalibration.
// ----------------------------------------------------------------------------
// Path: queue entry, then execute stage register, then output register.
// Throughput: one word per cycle unless the output stalls; a mark-open word,
//   or a write of slow_percent or initial_open_pulses, stalls the back end
//   while the span-times-percent multiplier register refreshes.
// Reset: synchronous; registers take their defaults, queue and output empty,
//   the first word after reset passes through without extra stalls.
// ----------------------------------------------------------------------------
module door_encoder_travel_limiter #(
  parameter int POS_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [dtl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dtl_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           mode,
  input  logic                                 dir_level,
  input  logic [31:0]                          now_ms,
  input  logic [1:0]                           motion,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [POS_WIDTH-1:0]          position,
  output logic signed [1:0]                    direction,
  output logic                                 slow,
  output logic                                 stop_request,
  output logic [1:0]                           door_end,
  output logic signed [POS_WIDTH-1:0]          open_span,
  output logic                                 persist
);
  import dtl_pkg::*;

  cfg_t     cfg;
  cfg_evt_t evt;
  logic     q_full;
  logic     push;
  cmd_t     push_cmd;
  logic     q_valid;
  cmd_t     q_cmd;
  logic     q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dir_high_close <= RST_DIR_POL;
      cfg.slow_pct       <= RST_SLOW_PCT;
      cfg.debounce       <= RST_DEBOUNCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIR_POL:  cfg.dir_high_close <= cfg_data[0];
        REG_SLOW_PCT: cfg.slow_pct       <= cfg_data[6:0];
        REG_DEBOUNCE: cfg.debounce       <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // startup loads of span and remembered end
  always_comb begin
    evt.load_span = cfg_we && (cfg_index == REG_INIT_SPAN);
    evt.load_end  = cfg_we && (cfg_index == REG_RESTORED_END);
    evt.pct_write = cfg_we && (cfg_index == REG_SLOW_PCT);
    evt.end_val   = (cfg_data[1:0] == LIMIT_CLOSED || cfg_data[1:0] == LIMIT_OPEN) ?
                    cfg_data[1:0] : LIMIT_NONE;
  end

  dtl_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .dir_level      (dir_level),
    .now_ms         (now_ms),
    .motion         (motion),
    .dir_high_close (cfg.dir_high_close),
    .q_full         (q_full),
    .push           (push),
    .cmd            (push_cmd)
  );

  dtl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_cmd),
    .pop      (q_pop)
  );

  dtl_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .evt          (evt),
    .span_raw     ($signed(cfg_data)),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .position     (position),
    .direction    (direction),
    .slow         (slow),
    .stop_request (stop_request),
    .door_end     (door_end),
    .open_span    (open_span),
    .persist      (persist)
  );

endmodule

@@ sv/dtl_checker.sv @@
// ----------------------------------------------------------------------------
// dtl_checker
// Port-level checks of the door encoder travel limiter, bound to the top.
// ----------------------------------------------------------------------------
module dtl_checker #(
  parameter int POS_WIDTH = 24
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [POS_WIDTH-1:0] position,
  input logic signed [1:0]           direction,
  input logic                        stop_request,
  input logic [1:0]                  door_end,
  input logic signed [POS_WIDTH-1:0] open_span,
  input logic                        persist
);
  import dtl_pkg::*;

  // a stalled result word keeps its position, persist, door end and direction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(persist)
      && $stable(door_end) && $stable(direction))
    else $error("result word changed while stalled");

  // every stop reaches an end and must be saved
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_request |-> persist)
    else $error("stop request without persist");

  // a saved closed end means position zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && persist && (door_end == LIMIT_CLOSED) |-> (position == '0))
    else $error("closed end saved away from zero");

  // a saved open end means position at the span
  assert property (@(posedge clk) disable iff (rst)
    out_valid && persist && (door_end == LIMIT_OPEN) |-> (position == open_span))
    else $error("open end saved away from span");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind door_encoder_travel_limiter dtl_checker #(
  .POS_WIDTH (POS_WIDTH)
) u_dtl_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .position     (position),
  .direction    (direction),
  .stop_request (stop_request),
  .door_end     (door_end),
  .open_span    (open_span),
  .persist      (persist)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for door_encoder_travel_limiter. A behavioral tracker
// of the door (position, span, end mark, slow flag, stop debounce) predicts
// one result word for every accepted input word. The checker compares each
// result word field by field against the oldest prediction. Directed words
// cover range saturation, wrapping time and the end codes. Random door runs
// follow, under three idle patterns, and then a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import dtl_pkg::*;

  localparam int POS_W = 24;
  localparam longint POS_HI = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_LO = -(longint'(1) << (POS_W - 1));

  localparam logic [1:0] MOTION_STOPPED = 2'd0;
  localparam logic [1:0] MOTION_OTHER   = 2'd3;
  localparam logic [1:0] END_BOGUS      = 2'd3;

  localparam int STALL_CYCLES  = 80;
  localparam int MAX_PRINTS    = 50;
  localparam int WORDS_PER_RUN = 100;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [1:0]       direction;
    logic                    slow;
    logic                    stop_request;
    logic [1:0]              door_end;
    logic signed [POS_W-1:0] open_span;
    logic                    persist;
  } door_report_t;

  // block inputs, all known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic [1:0]            mode      = MODE_PULSE;
  logic                  dir_level = 1'b0;
  logic [31:0]           now_ms    = '0;
  logic [1:0]            motion    = MOTION_STOPPED;
  logic                  out_ready = 1'b0;

  // block outputs
  logic                    in_ready;
  logic                    out_valid;
  logic signed [POS_W-1:0] position;
  logic signed [1:0]       direction;
  logic                    slow;
  logic                    stop_request;
  logic [1:0]              door_end;
  logic signed [POS_W-1:0] open_span;
  logic                    persist;

  // tracker state and its copy of the registers
  logic signed [POS_W-1:0] trk_pos       = '0;
  logic signed [1:0]       trk_dir       = DIR_NONE;
  logic signed [POS_W-1:0] trk_span      = RST_INIT_SPAN;
  logic [31:0]             trk_last_stop = '0;
  logic [1:0]              trk_end       = RST_RESTORED;
  logic                    trk_slow      = 1'b0;
  logic                    pol_close     = RST_DIR_POL;
  logic [6:0]              slow_pct_r    = RST_SLOW_PCT;
  logic [15:0]             debounce_r    = RST_DEBOUNCE;

  door_report_t expected_reports[$];

  int          error_count   = 0;
  int          checked_words = 0;
  int          send_gap_pct  = 0;
  int          recv_gap_pct  = 0;
  int          stall_left    = 0;
  logic        stall_req     = 1'b0;
  logic [31:0] ms_clock      = '0;
  logic [1:0]  travel        = MOTION_OPENING;

  door_encoder_travel_limiter #(.POS_WIDTH(POS_W)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .dir_level(dir_level), .now_ms(now_ms), .motion(motion),
    .out_valid(out_valid), .out_ready(out_ready),
    .position(position), .direction(direction), .slow(slow),
    .stop_request(stop_request), .door_end(door_end), .open_span(open_span),
    .persist(persist)
  );

  always #5 clk = ~clk;

  // tracker: register writes
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_DIR_POL:   pol_close  = d[0];
      REG_SLOW_PCT:  slow_pct_r = d[6:0];
      REG_DEBOUNCE:  debounce_r = d[15:0];
      REG_INIT_SPAN: trk_span   = d[POS_W-1:0];
      REG_RESTORED_END: begin
        trk_end = (d[1:0] == END_BOGUS) ? LIMIT_NONE : d[1:0];
        if (trk_end == LIMIT_CLOSED) trk_pos = '0;
        else if (trk_end == LIMIT_OPEN) trk_pos = trk_span;
      end
      default: ;
    endcase
  endfunction

  // tracker: one input word moves the door state and yields its report
  function automatic door_report_t step_travel(input logic [1:0] md, input logic lvl,
                                               input logic [31:0] t, input logic [1:0] mot);
    door_report_t r;
    longint       p;
    longint       s;
    longint       thr;
    longint       to_open;
    longint       dmin;
    logic [31:0]  elapsed;
    logic         stop;
    logic         keep;
    stop = 1'b0;
    keep = 1'b0;
    case (md)
      MODE_PULSE: begin
        trk_dir = (lvl == pol_close) ? DIR_CLOSE : DIR_OPEN;
        p = longint'(trk_pos) + longint'(trk_dir);
        if (p > POS_HI) p = POS_HI;
        else if (p < POS_LO) p = POS_LO;
        trk_pos = p[POS_W-1:0];
      end
      MODE_MARK_CLOSED: begin
        trk_pos = '0;
        trk_end = LIMIT_CLOSED;
        keep    = 1'b1;
      end
      MODE_MARK_OPEN: begin
        trk_span = trk_pos;
        trk_end  = LIMIT_OPEN;
        keep     = 1'b1;
      end
      MODE_TICK: begin
        if (mot == MOTION_OPENING || mot == MOTION_CLOSING) begin
          p = trk_pos;
          s = trk_span;
          // slow zone measured from the nearer end
          thr = (s * longint'(slow_pct_r)) / SLOW_SCALE;
          to_open = s - p;
          dmin = (p < to_open) ? p : to_open;
          trk_slow = (dmin <= thr);
          if ((mot == MOTION_OPENING) ? (p >= s) : (p <= 0)) begin
            elapsed = t - trk_last_stop;
            if (elapsed >= 32'(debounce_r)) begin
              stop = 1'b1;
              trk_last_stop = t;
              if (p <= 0) begin
                trk_pos = '0;
                trk_end = LIMIT_CLOSED;
                keep    = 1'b1;
              end else if (p >= s) begin
                trk_pos = trk_span;
                trk_end = LIMIT_OPEN;
                keep    = 1'b1;
              end
            end
            // closed end is forced even when the stop was debounced away
            if (mot == MOTION_CLOSING) begin
              trk_pos = '0;
              trk_end = LIMIT_CLOSED;
              keep    = 1'b1;
            end
          end
        end else begin
          trk_slow = 1'b0;
        end
      end
    endcase
    r.position     = trk_pos;
    r.direction    = trk_dir;
    r.slow         = trk_slow;
    r.stop_request = stop;
    r.door_end     = trk_end;
    r.open_span    = trk_span;
    r.persist      = keep;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTS) $display("mismatch at word %0d: %s", checked_words, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // result checker
  always @(posedge clk) begin
    door_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        flag_error("result word with nothing expected");
      end else begin
        want = expected_reports.pop_front();
        check_field("position", position, want.position);
        check_field("direction", direction, want.direction);
        check_field("slow", slow, want.slow);
        check_field("stop_request", stop_request, want.stop_request);
        check_field("door_end", door_end, want.door_end);
        check_field("open_span", open_span, want.open_span);
        check_field("persist", persist, want.persist);
      end
      checked_words++;
    end
  end

  // receiver: random idling, plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_req) begin
      stall_req  = 1'b0;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // offer one word, idling first at random, and return once it is taken
  task automatic send_word(input logic [1:0] md, input logic lvl, input logic [31:0] t,
                           input logic [1:0] mot);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= md;
    dir_level <= lvl;
    now_ms    <= t;
    motion    <= mot;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_reports.push_back(step_travel(md, lvl, t, mot));
  endtask

  // stop offering and wait until every result word is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  // write every register while the block is idle
  task automatic write_all(input logic pol, input logic [6:0] pct, input logic [15:0] deb,
                           input logic signed [23:0] span, input logic [1:0] rend);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] val[5];
    idx[0] = REG_DIR_POL;      val[0] = CFG_DATA_W'(pol);
    idx[1] = REG_SLOW_PCT;     val[1] = CFG_DATA_W'(pct);
    idx[2] = REG_DEBOUNCE;     val[2] = CFG_DATA_W'(deb);
    idx[3] = REG_INIT_SPAN;    val[3] = span;
    idx[4] = REG_RESTORED_END; val[4] = CFG_DATA_W'(rend);
    settle();
    for (int k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      apply_reg(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // defaults after reset: both pulse levels, every motion, both marks
  task automatic test_defaults();
    send_word(MODE_PULSE, 1'b1, 32'd0, MOTION_STOPPED);
    send_word(MODE_PULSE, 1'b0, 32'd0, MOTION_STOPPED);
    send_word(MODE_TICK, 1'b0, 32'd50, MOTION_STOPPED);
    send_word(MODE_TICK, 1'b0, 32'd0, MOTION_OPENING);
    // closing at the end inside the debounce window, then after it
    send_word(MODE_TICK, 1'b0, 32'd100, MOTION_CLOSING);
    send_word(MODE_TICK, 1'b0, 32'd600, MOTION_CLOSING);
    send_word(MODE_MARK_OPEN, 1'b1, 32'hFFFF_FFFF, MOTION_OTHER);
    send_word(MODE_MARK_CLOSED, 1'b0, 32'd0, MOTION_OPENING);
  endtask

  // position and span at both range limits, debounce extremes, time wrap
  task automatic test_saturation();
    write_all(1'b0, 7'd127, 16'd0, 24'sh7F_FFFF, LIMIT_OPEN);
    send_word(MODE_PULSE, 1'b1, 32'd0, MOTION_OPENING);
    send_word(MODE_TICK, 1'b0, 32'hFFFF_FFFF, MOTION_OPENING);
    send_word(MODE_TICK, 1'b1, 32'd0, MOTION_OTHER);
    write_all(1'b1, 7'd0, 16'hFFFF, 24'sh80_0000, LIMIT_OPEN);
    send_word(MODE_PULSE, 1'b1, 32'd0, MOTION_CLOSING);
    send_word(MODE_TICK, 1'b0, 32'h0000_FFFE, MOTION_CLOSING);
    send_word(MODE_TICK, 1'b0, 32'h0001_0000, MOTION_CLOSING);
    send_word(MODE_MARK_OPEN, 1'b0, 32'd0, MOTION_STOPPED);
  endtask

  // out-of-range restored end, zero span, full percent
  task automatic test_unknown_end();
    write_all(1'b1, 7'd100, 16'hFFFF, 24'sd0, END_BOGUS);
    send_word(MODE_PULSE, 1'b0, 32'd7, MOTION_STOPPED);
    send_word(MODE_TICK, 1'b1, 32'h8000_0000, MOTION_OPENING);
    send_word(MODE_MARK_CLOSED, 1'b1, 32'h5555_AAAA, MOTION_CLOSING);
  endtask

  // random small-span setup for a door run
  task automatic random_setup();
    logic              pol;
    logic [6:0]        pct;
    logic [15:0]       deb;
    logic signed [23:0] span;
    logic [1:0]        rend;
    pol  = 1'($urandom_range(1));
    pct  = 7'($urandom_range(127));
    deb  = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(600));
    span = 24'($urandom_range(60, 4));
    rend = 2'($urandom_range(3));
    write_all(pol, pct, deb, span, rend);
  endtask

  // door runs: pulses mostly follow the travel, ticks carry advancing time
  task automatic run_travel(input int n_words);
    int          pick;
    logic [1:0]  md;
    logic        lvl;
    logic [31:0] t;
    logic [1:0]  mot;
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(99) < 5) travel = $urandom_range(1) ? MOTION_OPENING : MOTION_CLOSING;
      pick = $urandom_range(99);
      lvl  = 1'($urandom_range(1));
      t    = $urandom;
      mot  = 2'($urandom_range(3));
      if (pick < 55) begin
        md = MODE_PULSE;
        if ($urandom_range(99) < 85) lvl = (travel == MOTION_CLOSING) ? pol_close : ~pol_close;
      end else if (pick < 85) begin
        md = MODE_TICK;
        if ($urandom_range(99) < 85) mot = travel;
        // mostly short steps, now and then a big jump that wraps
        ms_clock += ($urandom_range(19) == 0) ? $urandom : $urandom_range(150);
        t = ms_clock;
      end else if (pick < 92) begin
        md = MODE_MARK_CLOSED;
      end else begin
        md = MODE_MARK_OPEN;
      end
      send_word(md, lvl, t, mot);
    end
  endtask

  task automatic test_random_travel(input int send_pct, input int recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    for (int c = 0; c < 2; c++) begin
      random_setup();
      run_travel(WORDS_PER_RUN);
    end
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_setup();
    stall_req = 1'b1;
    run_travel(40);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_saturation();
    test_unknown_end();
    test_random_travel(8, 50);
    test_random_travel(50, 8);
    test_random_travel(0, 0);
    test_backpressure();
    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
sv/dtl_pkg.sv
sv/dtl_front.sv
sv/dtl_queue.sv
sv/dtl_back.sv
sv/door_encoder_travel_limiter.sv
sv/dtl_checker.sv
bench/tb.sv
